// ----- rtl/aabb_collide_resolve_core_macros.svh -----
// Assertion macros shared by the box collision checker.
`ifndef AABB_COLLIDE_RESOLVE_CORE_MACROS_SVH
`define AABB_COLLIDE_RESOLVE_CORE_MACROS_SVH

// Concurrent assertion sampled on clk and switched off while rst_n is low.
`define AABB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion sampled on clk that also holds during reset.
`define AABB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/aabb_pkg.sv -----
// Shared constants and beat types for the box collision resolver.
package aabb_pkg;

    // Field widths of the box and result beats.
    localparam int COORD_BITS     = 16;
    localparam int PUSH_FRAC_BITS = 8;
    localparam int SIZE_BITS      = COORD_BITS - 1;
    localparam int PUSH_BITS      = PUSH_FRAC_BITS + 1;

    // Internal widths: doubled centers, penetrations, products and sums.
    localparam int SSUM_BITS  = SIZE_BITS + 1;
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int CTR_BITS   = COORD_BITS + 3;
    localparam int PEN_BITS   = COORD_BITS + 4;
    localparam int D2_BITS    = COORD_BITS + 2;
    localparam int PROD_BITS  = D2_BITS + PUSH_BITS + 1;
    localparam int DELTA_BITS = PROD_BITS - PUSH_BITS;
    localparam int SUM_BITS   = COORD_BITS + 4;

    // Push weight of exactly one.
    localparam logic [PUSH_BITS-1:0] PUSH_ONE = PUSH_BITS'(1 << PUSH_FRAC_BITS);

    // One input beat: a box pair, its enables and the push weight.
    typedef struct packed {
        logic signed [COORD_BITS-1:0] a_x;
        logic signed [COORD_BITS-1:0] a_y;
        logic        [SIZE_BITS-1:0]  a_w;
        logic        [SIZE_BITS-1:0]  a_h;
        logic signed [COORD_BITS-1:0] b_x;
        logic signed [COORD_BITS-1:0] b_y;
        logic        [SIZE_BITS-1:0]  b_w;
        logic        [SIZE_BITS-1:0]  b_h;
        logic                         a_enabled;
        logic                         b_enabled;
        logic        [PUSH_BITS-1:0]  push_weight;
    } box_t;

    // One result beat.
    typedef struct packed {
        logic                         overlap;
        logic                         on_ground;
        logic signed [COORD_BITS-1:0] a_new_x;
        logic signed [COORD_BITS-1:0] a_new_y;
        logic signed [COORD_BITS-1:0] b_new_x;
        logic signed [COORD_BITS-1:0] b_new_y;
    } res_t;

    // Geometry stage output: flags, chosen axis and signed doubled penetration.
    typedef struct packed {
        logic                         ovl;
        logic                         gnd;
        logic                         use_y;
        logic signed [D2_BITS-1:0]    d2;
        logic        [PUSH_BITS-1:0]  push;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
    } geom_t;

endpackage

// ----- rtl/aabb_geom.sv -----
// Overlap test, ground test and choice of the resolution axis.
module aabb_geom
    import aabb_pkg::*;
(
    input  box_t  box,
    output geom_t geom
);

    logic signed [CTR_BITS-1:0]  acx;
    logic signed [CTR_BITS-1:0]  acy;
    logic signed [CTR_BITS-1:0]  bcx;
    logic signed [CTR_BITS-1:0]  bcy;
    logic signed [CTR_BITS-1:0]  dx2;
    logic signed [CTR_BITS-1:0]  dy2;
    logic signed [CTR_BITS-1:0]  adx;
    logic signed [CTR_BITS-1:0]  ady;
    logic        [SSUM_BITS-1:0] sw;
    logic        [SSUM_BITS-1:0] sh;
    logic signed [PEN_BITS-1:0]  ix2;
    logic signed [PEN_BITS-1:0]  iy2;
    logic signed [PEN_BITS-1:0]  pen;
    logic signed [PEN_BITS-1:0]  d2_full;
    logic signed [EDGE_BITS-1:0] a_bot;
    logic signed [EDGE_BITS-1:0] b_top;
    logic                        act;
    logic                        x_hit;
    logic                        y_hit;
    logic                        ovl;
    logic                        use_y;
    logic                        pos_dir;

    // Doubled centers and their offsets, so no halving bit is lost.
    always_comb
    begin
        acx = (CTR_BITS'(box.a_x) <<< 1) + CTR_BITS'(box.a_w);
        acy = (CTR_BITS'(box.a_y) <<< 1) + CTR_BITS'(box.a_h);
        bcx = (CTR_BITS'(box.b_x) <<< 1) + CTR_BITS'(box.b_w);
        bcy = (CTR_BITS'(box.b_y) <<< 1) + CTR_BITS'(box.b_h);
        dx2 = bcx - acx;
        dy2 = bcy - acy;
        adx = dx2[CTR_BITS-1] ? -dx2 : dx2;
        ady = dy2[CTR_BITS-1] ? -dy2 : dy2;
    end

    // Doubled penetrations: zero or negative means the axis overlaps.
    always_comb
    begin
        sw  = SSUM_BITS'(box.a_w) + SSUM_BITS'(box.b_w);
        sh  = SSUM_BITS'(box.a_h) + SSUM_BITS'(box.b_h);
        ix2 = PEN_BITS'(adx) - PEN_BITS'(sw);
        iy2 = PEN_BITS'(ady) - PEN_BITS'(sh);
    end

    // Flags and the resolution axis; ties between the axes go vertical.
    always_comb
    begin
        act   = box.a_enabled & box.b_enabled;
        x_hit = (ix2 <= 0);
        y_hit = (iy2 <= 0);
        ovl   = act & x_hit & y_hit;
        a_bot = EDGE_BITS'(box.a_y) + EDGE_BITS'(box.a_h);
        b_top = EDGE_BITS'(box.b_y);
        use_y = !(ix2 > iy2);
    end

    // Signed correction for the first box; a zero offset pushes it positive.
    always_comb
    begin
        pen     = use_y ? iy2 : ix2;
        pos_dir = use_y ? (dy2 > 0) : (dx2 > 0);
        d2_full = pos_dir ? pen : -pen;
    end

    // Pack the stage output; without an overlap the correction is zero.
    always_comb
    begin
        geom.ovl   = ovl;
        geom.gnd   = act & x_hit & (a_bot <= b_top);
        geom.use_y = use_y;
        geom.d2    = ovl ? D2_BITS'(d2_full) : '0;
        geom.push  = (box.push_weight > PUSH_ONE) ? PUSH_ONE : box.push_weight;
        geom.ax    = box.a_x;
        geom.ay    = box.a_y;
        geom.bx    = box.b_x;
        geom.by    = box.b_y;
    end

endmodule

// ----- rtl/aabb_move.sv -----
// Weighted split of the correction, floored shift and saturated positions.
module aabb_move
    import aabb_pkg::*;
(
    input  geom_t geom,
    output res_t  res
);

    logic signed [PROD_BITS-1:0]  d2_ext;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [PROD_BITS-1:0]  a_mov;
    logic signed [PROD_BITS-1:0]  b_mov;
    logic signed [DELTA_BITS-1:0] a_del;
    logic signed [DELTA_BITS-1:0] b_del;
    logic signed [SUM_BITS-1:0]   a_dx;
    logic signed [SUM_BITS-1:0]   a_dy;
    logic signed [SUM_BITS-1:0]   b_dx;
    logic signed [SUM_BITS-1:0]   b_dy;

    // Clamp a wide sum to the signed coordinate range.
    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [SUM_BITS-1:0] v
    );
        logic [SUM_BITS-COORD_BITS:0] top;
        top = v[SUM_BITS-1:COORD_BITS-1];
        if (top == '0 || top == '1)
        begin
            return v[COORD_BITS-1:0];
        end
        else if (v[SUM_BITS-1])
        begin
            return {1'b1, {(COORD_BITS-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(COORD_BITS-1){1'b1}}};
        end
    endfunction

    // One multiply: the first box share is d2*ONE minus d2*p.
    always_comb
    begin
        d2_ext = PROD_BITS'(geom.d2);
        prod   = d2_ext * PROD_BITS'($signed({1'b0, geom.push}));
        a_mov  = (d2_ext <<< PUSH_FRAC_BITS) - prod;
        b_mov  = -prod;
    end

    // Arithmetic shift floors; the extra bit undoes the doubling.
    always_comb
    begin
        a_del = DELTA_BITS'(a_mov >>> PUSH_BITS);
        b_del = DELTA_BITS'(b_mov >>> PUSH_BITS);
    end

    // Apply the moves on the chosen axis only.
    always_comb
    begin
        a_dx = geom.use_y ? '0 : SUM_BITS'(a_del);
        a_dy = geom.use_y ? SUM_BITS'(a_del) : '0;
        b_dx = geom.use_y ? '0 : SUM_BITS'(b_del);
        b_dy = geom.use_y ? SUM_BITS'(b_del) : '0;
    end

    // Saturated new positions and the flags.
    always_comb
    begin
        res.overlap   = geom.ovl;
        res.on_ground = geom.gnd;
        res.a_new_x   = sat_coord(SUM_BITS'(geom.ax) + a_dx);
        res.a_new_y   = sat_coord(SUM_BITS'(geom.ay) + a_dy);
        res.b_new_x   = sat_coord(SUM_BITS'(geom.bx) + b_dx);
        res.b_new_y   = sat_coord(SUM_BITS'(geom.by) + b_dy);
    end

endmodule

// ----- rtl/aabb_collide_resolve_core.sv -----
// An accepted beat is held in the middle register, then in the result register.
// Throughput: one beat per cycle while res_stall is low; geometry feeds the middle
// register; the one-multiplier weighted move sits between middle and result registers.
// Two registered stages buffer beats, so input is taken while a result waits.
// Reset (rst_n low, asynchronous) empties both stages; no other state exists.
// Payload registers are not reset.
module aabb_collide_resolve_core
    import aabb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic box_valid,
    output logic box_stall,
    input  box_t box,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic  mid_valid_reg;
    logic  mid_valid_next;
    geom_t mid_reg;
    geom_t mid_next;
    logic  res_valid_reg;
    logic  res_valid_next;
    res_t  res_reg;
    res_t  res_next;
    logic  adv_out;
    logic  adv_mid;

    // Geometry stage on the incoming beat.
    aabb_geom u_geom
    (
        .box  (box),
        .geom (mid_next)
    );

    // Move stage on the registered geometry.
    aabb_move u_move
    (
        .geom (mid_reg),
        .res  (res_next)
    );

    // A stage advances when it is empty or the stage after it advances.
    always_comb
    begin
        adv_out        = !res_valid_reg || !res_stall;
        adv_mid        = !mid_valid_reg || adv_out;
        box_stall      = !adv_mid;
        mid_valid_next = adv_mid ? box_valid : mid_valid_reg;
        res_valid_next = adv_out ? mid_valid_reg : res_valid_reg;
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            mid_valid_reg <= mid_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Stage payloads load only when their stage advances with a beat.
    always_ff @(posedge clk)
    begin
        if (adv_mid && box_valid)
        begin
            mid_reg <= mid_next;
        end
        if (adv_out && mid_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- rtl/aabb_chk.sv -----
// Port-level checker for the box collision resolver and its bind.
`include "aabb_collide_resolve_core_macros.svh"

module aabb_chk
    import aabb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic box_valid,
    input logic box_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] occ_reg;
    logic [1:0] occ_next;

    // Count beats taken in and not yet delivered.
    always_comb
    begin
        in_acc   = box_valid && !box_stall;
        out_acc  = res_valid && !res_stall;
        occ_next = occ_reg + 2'(in_acc) - 2'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 2'd0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    `AABB_ASSERT(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res), "stalled result beat changed")
    `AABB_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !res_valid, "result valid right after reset")
    `AABB_ASSERT(a_free_take, !res_valid |-> !box_stall, "input stalled with empty output")
    `AABB_ASSERT(a_occ_max, occ_reg != 2'd3, "more beats in flight than stages")
    `AABB_ASSERT(a_occ_out, res_valid |-> occ_reg != 2'd0, "result beat without an accepted input")

endmodule

bind aabb_collide_resolve_core aabb_chk u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .box_valid (box_valid),
    .box_stall (box_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

// ----- tb/aabb_collide_resolve_core_tb.sv -----
// Self-checking testbench for the box pair overlap and resolution core.
module aabb_collide_resolve_core_tb;
    import aabb_pkg::*;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT = 4000;
    // Length of the long output hold used to back up the pipeline.
    localparam int HOLD_CYCLES = 300;
    // Extremes of a signed coordinate.
    localparam longint COORD_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -COORD_MAX - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic box_valid = 1'b0;
    logic box_stall;
    box_t box = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    // Expected result beats, oldest first.
    res_t pending_resolutions[$];
    res_t want;
    int errors = 0;
    int quiet_cycles = 0;
    bit idle_en = 1'b1;
    bit hold_req = 1'b0;

    aabb_collide_resolve_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .box_valid (box_valid),
        .box_stall (box_stall),
        .box       (box),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Saturate a wide position to the signed coordinate range.
    function automatic logic signed [COORD_BITS-1:0] clamp_coord(longint v);
        if (v > COORD_MAX)
            v = COORD_MAX;
        if (v < COORD_MIN)
            v = COORD_MIN;
        return COORD_BITS'(v);
    endfunction

    // Overlap test and minimum-penetration push-apart of one box pair.
    function automatic res_t resolve_pair(box_t b);
        longint ax, ay, aw, ah, bx, by, bw, bh;
        longint one, p, dx2, dy2, ix2, iy2, d2;
        longint nax, nay, nbx, nby;
        res_t r;
        ax = $signed(b.a_x);
        ay = $signed(b.a_y);
        bx = $signed(b.b_x);
        by = $signed(b.b_y);
        aw = b.a_w;
        ah = b.a_h;
        bw = b.b_w;
        bh = b.b_h;
        one = longint'(1) << PUSH_FRAC_BITS;
        p = b.push_weight;
        if (p > one)
            p = one;
        nax = ax;
        nay = ay;
        nbx = bx;
        nby = by;
        r.overlap = 1'b0;
        r.on_ground = 1'b0;
        // Doubled center offsets and doubled penetrations (zero or negative when overlapping).
        dx2 = (2 * bx + bw) - (2 * ax + aw);
        dy2 = (2 * by + bh) - (2 * ay + ah);
        ix2 = ((dx2 < 0) ? -dx2 : dx2) - (aw + bw);
        iy2 = ((dy2 < 0) ? -dy2 : dy2) - (ah + bh);
        if (b.a_enabled && b.b_enabled)
        begin
            r.on_ground = (ix2 <= 0) && (ay + ah <= by);
            if (ix2 <= 0 && iy2 <= 0)
            begin
                r.overlap = 1'b1;
                // The shallower axis wins; a tie goes to the vertical axis.
                if (ix2 > iy2)
                begin
                    d2 = (dx2 > 0) ? ix2 : -ix2;
                    nax = ax + ((d2 * (one - p)) >>> (PUSH_FRAC_BITS + 1));
                    nbx = bx + ((-d2 * p) >>> (PUSH_FRAC_BITS + 1));
                end
                else
                begin
                    d2 = (dy2 > 0) ? iy2 : -iy2;
                    nay = ay + ((d2 * (one - p)) >>> (PUSH_FRAC_BITS + 1));
                    nby = by + ((-d2 * p) >>> (PUSH_FRAC_BITS + 1));
                end
            end
        end
        r.a_new_x = clamp_coord(nax);
        r.a_new_y = clamp_coord(nay);
        r.b_new_x = clamp_coord(nbx);
        r.b_new_y = clamp_coord(nby);
        return r;
    endfunction

    // Build a box pair beat from plain integers.
    function automatic box_t make_pair(int ax, int ay, int aw, int ah, int bx, int by,
                                       int bw, int bh, int ea, int eb, int p);
        box_t b;
        b.a_x = COORD_BITS'(ax);
        b.a_y = COORD_BITS'(ay);
        b.a_w = SIZE_BITS'(aw);
        b.a_h = SIZE_BITS'(ah);
        b.b_x = COORD_BITS'(bx);
        b.b_y = COORD_BITS'(by);
        b.b_w = SIZE_BITS'(bw);
        b.b_h = SIZE_BITS'(bh);
        b.a_enabled = ea[0];
        b.b_enabled = eb[0];
        b.push_weight = PUSH_BITS'(p);
        return b;
    endfunction

    // Random box pair: mostly nearby boxes, sometimes fully random fields.
    function automatic box_t random_pair();
        box_t b;
        int kind;
        int aw, ah, bw, bh, off;
        kind = $urandom_range(9);
        b.a_x = COORD_BITS'($urandom);
        b.a_y = COORD_BITS'($urandom);
        b.a_w = SIZE_BITS'($urandom);
        b.a_h = SIZE_BITS'($urandom);
        b.b_x = COORD_BITS'($urandom);
        b.b_y = COORD_BITS'($urandom);
        b.b_w = SIZE_BITS'($urandom);
        b.b_h = SIZE_BITS'($urandom);
        b.a_enabled = 1'($urandom_range(1));
        b.b_enabled = 1'($urandom_range(1));
        b.push_weight = PUSH_BITS'($urandom);
        if (kind < 7)
        begin
            // Nearby pair: most sizes small, b placed so the boxes touch, overlap or sit just apart.
            if ($urandom_range(3) != 0)
            begin
                b.a_w = SIZE_BITS'($urandom_range(2047));
                b.a_h = SIZE_BITS'($urandom_range(2047));
                b.b_w = SIZE_BITS'($urandom_range(2047));
                b.b_h = SIZE_BITS'($urandom_range(2047));
            end
            if (kind == 6)
            begin
                b.a_x = ($urandom_range(1) != 0) ? COORD_BITS'(COORD_MAX - $urandom_range(255))
                                                 : COORD_BITS'(COORD_MIN + $urandom_range(255));
                b.a_y = ($urandom_range(1) != 0) ? COORD_BITS'(COORD_MAX - $urandom_range(255))
                                                 : COORD_BITS'(COORD_MIN + $urandom_range(255));
            end
            aw = b.a_w;
            ah = b.a_h;
            bw = b.b_w;
            bh = b.b_h;
            off = int'($urandom_range(aw + bw + 64)) - bw - 32;
            b.b_x = COORD_BITS'(int'(b.a_x) + off);
            off = int'($urandom_range(ah + bh + 64)) - bh - 32;
            b.b_y = COORD_BITS'(int'(b.a_y) + off);
            b.a_enabled = ($urandom_range(9) != 0);
            b.b_enabled = ($urandom_range(9) != 0);
            b.push_weight = ($urandom_range(7) == 0) ? PUSH_BITS'($urandom_range(511, 257))
                                                    : PUSH_BITS'($urandom_range(256));
        end
        return b;
    endfunction

    // Offer one box pair beat after a random gap and hold it until taken.
    task automatic send_box(box_t b);
        int gap;
        bit took;
        gap = idle_en ? $urandom_range(16) : 0;
        repeat (gap)
        begin
            box_valid <= 1'b0;
            @(posedge clk);
        end
        box_valid <= 1'b1;
        box <= b;
        do
        begin
            @(negedge clk);
            took = !box_stall;
            @(posedge clk);
        end
        while (!took);
        pending_resolutions.push_back(resolve_pair(b));
    endtask

    // Drop valid and wait until every expected result beat has arrived.
    task automatic wait_all_results();
        box_valid <= 1'b0;
        while (pending_resolutions.size() != 0)
            @(posedge clk);
    endtask

    // Extremes and each special case of the resolution.
    task automatic test_directed();
        send_box(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0));
        // Identical boxes: zero offset on both axes, vertical axis, first box pushed positive.
        send_box(make_pair(0, 0, 160, 160, 0, 0, 160, 160, 1, 1, 128));
        // First box resting exactly on top of the second.
        send_box(make_pair(0, 0, 160, 160, 0, 160, 160, 160, 1, 1, 128));
        send_box(make_pair(0, 0, 160, 170, 0, 160, 160, 160, 1, 1, 128));
        // Horizontal resolution and touching along x.
        send_box(make_pair(0, 0, 160, 160, 150, 20, 160, 160, 1, 1, 64));
        send_box(make_pair(0, 0, 160, 160, 160, 0, 160, 160, 1, 1, 64));
        send_box(make_pair(0, 0, 160, 160, 400, 0, 160, 160, 1, 1, 64));
        // Disabled boxes pass through.
        send_box(make_pair(0, 0, 160, 160, 10, 10, 160, 160, 0, 1, 64));
        send_box(make_pair(0, 0, 160, 160, 10, 10, 160, 160, 1, 0, 64));
        send_box(make_pair(0, 0, 160, 160, 10, 10, 160, 160, 0, 0, 64));
        // Push weight at one and above one.
        send_box(make_pair(0, 0, 160, 160, 30, 5, 160, 160, 1, 1, 256));
        send_box(make_pair(0, 0, 160, 160, 30, 5, 160, 160, 1, 1, 257));
        send_box(make_pair(0, 0, 160, 160, 30, 5, 160, 160, 1, 1, 511));
        // Saturation at both ends of the range.
        send_box(make_pair(32767, 0, 32767, 32767, 16000, 0, 32767, 32767, 1, 1, 0));
        send_box(make_pair(-32768, 0, 32767, 32767, -16768, 0, 32767, 32767, 1, 1, 0));
        send_box(make_pair(16000, 0, 32767, 32767, 32767, 0, 32767, 32767, 1, 1, 256));
        send_box(make_pair(-16768, 0, 32767, 32767, -32768, 0, 32767, 32767, 1, 1, 256));
        send_box(make_pair(32767, 32767, 32767, 32767, -32768, -32768, 32767, 32767, 1, 1, 511));
        // First box below the second, and an axis tie with a nonzero offset.
        send_box(make_pair(0, 150, 160, 160, 0, 0, 160, 160, 1, 1, 100));
        send_box(make_pair(0, 0, 160, 160, 10, 10, 160, 160, 1, 1, 200));
        wait_all_results();
    endtask

    // Random pairs with random gaps on both sides.
    task automatic test_random_traffic(int count);
        idle_en = 1'b1;
        repeat (count)
            send_box(random_pair());
    endtask

    // Random pairs with no idling on either side.
    task automatic test_back_to_back(int count);
        idle_en = 1'b0;
        repeat (count)
            send_box(random_pair());
        idle_en = 1'b1;
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering beats.
    task automatic test_output_hold(int count);
        idle_en = 1'b0;
        hold_req = 1'b1;
        repeat (count)
            send_box(random_pair());
        idle_en = 1'b1;
    endtask

    // Sender stops mid-stream until the pipeline has fully drained.
    task automatic test_pause_mid_stream(int count);
        repeat (count)
            send_box(random_pair());
        wait_all_results();
        repeat (count)
            send_box(random_pair());
    endtask

    // Compare one field of a result beat.
    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
        end
    endtask

    // Result receiver: random stall before each beat, plus one long hold on request.
    initial
    begin : result_sink
        int n;
        bit took;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            n = idle_en ? $urandom_range(16) : 0;
            repeat (n)
            begin
                res_stall <= 1'b1;
                @(posedge clk);
            end
            res_stall <= 1'b0;
            do
            begin
                @(negedge clk);
                took = res_valid;
                @(posedge clk);
            end
            while (!took);
        end
    end

    // A result beat seen with valid high and stall low is taken at the next edge.
    always @(negedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_resolutions.size() == 0)
            begin
                errors++;
                $display("%0t: result beat with no expectation, expected none, actual %h",
                         $realtime, res);
            end
            else
            begin
                want = pending_resolutions.pop_front();
                check_field("overlap", want.overlap, res.overlap);
                check_field("on_ground", want.on_ground, res.on_ground);
                check_field("a_new_x", want.a_new_x, res.a_new_x);
                check_field("a_new_y", want.a_new_y, res.a_new_y);
                check_field("b_new_x", want.b_new_x, res.b_new_x);
                check_field("b_new_y", want.b_new_y, res.b_new_y);
            end
        end
    end

    // Watchdog on cycles where neither channel moves a beat.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((box_valid && !box_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat accepted for %0d cycles", $realtime, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic(1000);
        test_back_to_back(500);
        test_output_hold(40);
        test_pause_mid_stream(100);
        test_random_traffic(100);
        wait_all_results();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
